// ===== hw/rtl/cantx_pkg.sv =====
// Shared types and constants of the CAN transport transmit segmenter.
package cantx_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  localparam logic [10:0] BASE_ID     = 11'h600;
  localparam logic [7:0]  PAD_BYTE    = 8'hAA;
  localparam logic [3:0]  FF_PCI      = 4'h1;
  localparam logic [3:0]  CF_PCI      = 4'h2;
  localparam logic [11:0] SF_MAX_LEN  = 12'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENDER_ID = 1'b0,
    REG_TARGET_ID = 1'b1
  } cfg_reg_e;

  // Data bytes 1 to 7 of a finished frame; byte 0 and the identifier are added on output.
  typedef struct packed {
    logic [7:1][7:0] data;
    logic            final_frame;
  } frm_t;

  typedef struct packed {
    logic valid;
    frm_t frame;
  } frm_push_t;

endpackage

// ===== hw/rtl/cantx_intf.sv =====
// Channel interfaces of the segmenter: message bytes in, frames out, configuration writes.
interface cantx_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [7:0]  data_byte;
  logic [11:0] msg_length;

  modport source (output valid, start_req, data_byte, msg_length, input ready);
  modport sink (input valid, start_req, data_byte, msg_length, output ready);
endinterface

interface cantx_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] frame_id;
  logic [7:0]  byte_zero;
  logic [7:0]  byte_one;
  logic [7:0]  byte_two;
  logic [7:0]  byte_three;
  logic [7:0]  byte_four;
  logic [7:0]  byte_five;
  logic [7:0]  byte_six;
  logic [7:0]  byte_seven;
  logic        final_frame;

  modport source (output valid, frame_id, byte_zero, byte_one, byte_two, byte_three,
                  byte_four, byte_five, byte_six, byte_seven, final_frame, input ready);
  modport sink (input valid, frame_id, byte_zero, byte_one, byte_two, byte_three,
                byte_four, byte_five, byte_six, byte_seven, final_frame, output ready);
endinterface

interface cantx_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/can_transport_tx_segmenter.sv =====
// Top level of the CAN transport transmit segmenter.
// Takes one message byte per clock and emits 8-byte CAN frames with extended addressing: a single
// frame for messages of up to 6 bytes, otherwise a first frame and consecutive frames of six
// bytes each, padded with 0xAA. The front end updates its fill counter and frame bytes in the
// cycle a byte is accepted, so input runs at one transaction per cycle; a finished frame enters a
// two-entry queue and passes from there to a registered output stage.
// Input stalls while the queue is full, which happens only after the output register has held a
// frame that was not taken; input resumes in the cycle after the output takes a frame.
// Configuration writes are accepted every cycle and should be made while no message is in flight.
module can_transport_tx_segmenter (
  input  logic         clk_i,
  input  logic         rst_ni,
  cantx_in_if.sink     in_i,
  cantx_cfg_if.sink    cfg_i,
  cantx_out_if.source  out_o
);
  import cantx_pkg::*;

  frm_push_t push;
  logic      push_ready;
  logic      pop_valid;
  frm_t      pop_frame;
  logic      pop;

  cantx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  cantx_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_frame_o  (pop_frame),
    .pop_i        (pop)
  );

  cantx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pop_valid_i (pop_valid),
    .pop_frame_i (pop_frame),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// ===== hw/rtl/cantx_front.sv =====
// Front end: takes message bytes, assembles frame bytes and hands finished frames to the queue.
module cantx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  cantx_in_if.sink            in_i,
  output cantx_pkg::frm_push_t push_o,
  input  logic                push_ready_i
);
  import cantx_pkg::*;

  logic [7:1][7:0] data_q, data_d, wr_data;
  logic [2:0]      fill_q, fill_d;
  logic [11:0]     rem_q, rem_d, rem_dec;
  logic [3:0]      seq_q, seq_d;
  logic            open_q, open_d;
  logic            accept;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid & push_ready_i;
  assign rem_dec    = rem_q - 12'd1;

  always_comb begin
    wr_data = data_q;
    for (int i = 1; i < 8; i++) begin
      if (fill_q == 3'(i)) begin
        wr_data[i] = in_i.data_byte;
      end
    end
  end

  always_comb begin
    data_d            = data_q;
    fill_d            = fill_q;
    rem_d             = rem_q;
    seq_d             = seq_q;
    open_d            = open_q;
    push_o.valid      = 1'b0;
    push_o.frame.data = wr_data;
    push_o.frame.final_frame = 1'b0;
    if (accept) begin
      if (in_i.start_req) begin
        // A start always opens a fresh message; any open one is dropped.
        open_d = 1'b1;
        rem_d  = (in_i.msg_length != 12'd0) ? in_i.msg_length - 12'd1 : 12'd0;
        seq_d  = 4'd1;
        data_d = {7{PAD_BYTE}};
        if (in_i.msg_length > SF_MAX_LEN) begin
          data_d[1] = {FF_PCI, in_i.msg_length[11:8]};
          data_d[2] = in_i.msg_length[7:0];
          data_d[3] = in_i.data_byte;
          fill_d    = 3'd4;
        end else begin
          data_d[1] = in_i.msg_length[7:0];
          data_d[2] = in_i.data_byte;
          fill_d    = 3'd3;
          if (in_i.msg_length <= 12'd1) begin
            push_o.valid             = 1'b1;
            push_o.frame.data        = data_d;
            push_o.frame.final_frame = 1'b1;
            open_d                   = 1'b0;
          end
        end
      end else if (open_q) begin
        rem_d  = rem_dec;
        fill_d = fill_q + 3'd1;
        data_d = wr_data;
        if (rem_dec == 12'd0 || fill_q == 3'd7) begin
          push_o.valid             = 1'b1;
          push_o.frame.final_frame = (rem_dec == 12'd0);
          if (rem_dec == 12'd0) begin
            open_d = 1'b0;
          end else begin
            data_d    = {7{PAD_BYTE}};
            data_d[1] = {CF_PCI, seq_q};
            seq_d     = seq_q + 4'd1;
            fill_d    = 3'd2;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rem_q  <= '0;
      seq_q  <= '0;
      open_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      rem_q  <= rem_d;
      seq_q  <= seq_d;
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ===== hw/rtl/cantx_fifo.sv =====
// Short frame queue between the front end and the output stage.
module cantx_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cantx_pkg::frm_push_t push_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output cantx_pkg::frm_t      pop_frame_o,
  input  logic                 pop_i
);
  import cantx_pkg::*;

  frm_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_frame_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.frame;
    end
  end

endmodule

// ===== hw/rtl/cantx_back.sv =====
// Output stage: holds the configuration registers and the registered outgoing frame.
module cantx_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  cantx_cfg_if.sink       cfg_i,
  input  logic            pop_valid_i,
  input  cantx_pkg::frm_t pop_frame_i,
  output logic            pop_o,
  cantx_out_if.source     out_o
);
  import cantx_pkg::*;

  logic [7:0] sender_q;
  logic [7:0] target_q;
  logic       valid_q;
  frm_t       frame_q;

  assign cfg_i.ready = 1'b1;
  assign pop_o       = pop_valid_i & (~valid_q | out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sender_q <= '0;
      target_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_SENDER_ID: sender_q <= cfg_i.data;
          REG_TARGET_ID: target_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (pop_o) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      frame_q <= pop_frame_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.frame_id    = BASE_ID + {3'b000, sender_q};
  assign out_o.byte_zero   = target_q;
  assign out_o.byte_one    = frame_q.data[1];
  assign out_o.byte_two    = frame_q.data[2];
  assign out_o.byte_three  = frame_q.data[3];
  assign out_o.byte_four   = frame_q.data[4];
  assign out_o.byte_five   = frame_q.data[5];
  assign out_o.byte_six    = frame_q.data[6];
  assign out_o.byte_seven  = frame_q.data[7];
  assign out_o.final_frame = frame_q.final_frame;

endmodule

// ===== hw/rtl/cantx_checker.sv =====
// Port-level checks of the segmenter output, bound to the top level.
module cantx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [10:0] frame_id_i,
  input logic [7:0]  byte_one_i,
  input logic        final_frame_i
);

  // A frame that is not taken stays on the output.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_one_i))
    else $error("output frame dropped or changed while stalled");

  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> frame_id_i[10:8] == 3'b110)
    else $error("frame identifier outside the diagnostic range");

  a_pci_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> byte_one_i[7:4] == 4'h0 || byte_one_i[7:4] == 4'h1
                    || byte_one_i[7:4] == 4'h2)
    else $error("unknown frame type in control byte");

  // A first frame never ends a message, and a single frame always does.
  a_ff_not_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_one_i[7:4] == 4'h1 |-> !final_frame_i)
    else $error("first frame marked as final");

  a_sf_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_one_i[7:4] == 4'h0 |-> final_frame_i)
    else $error("single frame not marked as final");

endmodule

bind can_transport_tx_segmenter cantx_checker u_cantx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .frame_id_i    (out_o.frame_id),
  .byte_one_i    (out_o.byte_one),
  .final_frame_i (out_o.final_frame)
);

// ===== test/can_transport_tx_segmenter_tb.sv =====
// Self-checking testbench of the CAN transport transmit segmenter with a frame predictor.
module can_transport_tx_segmenter_tb;
  import cantx_pkg::*;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DIR_N           = 20;
  localparam logic [1:7][7:0] NO_FRAME = '0;

  typedef struct packed {
    logic [10:0]     frame_id;
    logic [0:7][7:0] data;
    logic            final_frame;
  } can_frame_t;

  // One directed transaction; bytes holds data bytes 1 to 7 of a frame typed in by hand.
  typedef struct packed {
    logic            start;
    logic [7:0]      data;
    logic [11:0]     len;
    logic            typed;
    logic [1:7][7:0] bytes;
    logic            fin;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cantx_in_if  in_bus ();
  cantx_out_if out_bus ();
  cantx_cfg_if cfg_bus ();

  can_transport_tx_segmenter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (out_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: registers and the frame under assembly.
  logic [7:0]      sender_id_q;
  logic [7:0]      target_id_q;
  logic [0:7][7:0] seg_bytes;
  logic [2:0]      fill_pos;
  logic [11:0]     remaining;
  logic [3:0]      seq_no;
  logic            msg_open;

  can_frame_t frames_due[$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         idle_odds = 0;
  logic       calm = 1'b0;
  logic       hold_req = 1'b0;
  int         stall_left = 0;
  int         idle_cycles = 0;

  dir_row_t dir_rows [DIR_N] = '{
    // A byte with no message open is dropped.
    {1'b0, 8'h55, 12'h000, 1'b0, NO_FRAME, 1'b0},
    {1'b1, 8'h3E, 12'd1, 1'b1, {8'h01, 8'h3E, {5{8'hAA}}}, 1'b1},
    // Zero length leaves at once as a single frame holding only the service byte.
    {1'b1, 8'hFF, 12'd0, 1'b1, {8'h00, 8'hFF, {5{8'hAA}}}, 1'b1},
    {1'b1, 8'h22, 12'd6, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'h00, 12'hFFF, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'hFF, 12'h000, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'h01, 12'hFFF, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'h80, 12'h000, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'h7F, 12'hFFF, 1'b1, {8'h06, 8'h22, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F}, 1'b1},
    // Longest message, abandoned by the next start.
    {1'b1, 8'h31, 12'd4095, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'hA5, 12'h000, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'h5A, 12'h000, 1'b0, NO_FRAME, 1'b0},
    {1'b1, 8'h10, 12'd7, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'h01, 12'h000, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'h02, 12'h000, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'h03, 12'h000, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'h04, 12'h000, 1'b1, {8'h10, 8'h07, 8'h10, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b0},
    {1'b0, 8'h05, 12'h000, 1'b0, NO_FRAME, 1'b0},
    {1'b0, 8'h06, 12'h000, 1'b1, {8'h21, 8'h05, 8'h06, {4{8'hAA}}}, 1'b1},
    {1'b0, 8'hC3, 12'hFFF, 1'b0, NO_FRAME, 1'b0}
  };

  function automatic can_frame_t frame_out(input logic fin);
    return {BASE_ID + {3'b000, sender_id_q}, target_id_q, seg_bytes[1:7], fin};
  endfunction

  // Advances the segmenter by one accepted byte; returns 1 when a frame completes.
  function automatic bit segment_byte(input logic start, input logic [7:0] b,
                                      input logic [11:0] len, output can_frame_t frm);
    logic is_full;
    logic is_last;
    frm = '0;
    if (start) begin
      msg_open = 1'b1;
      remaining = (len >= 12'd1) ? len - 12'd1 : 12'd0;
      seq_no = 4'd1;
      seg_bytes = {8{PAD_BYTE}};
      seg_bytes[0] = 8'h00;
      if (len > SF_MAX_LEN) begin
        seg_bytes[1] = {FF_PCI, len[11:8]};
        seg_bytes[2] = len[7:0];
        seg_bytes[3] = b;
        fill_pos = 3'd4;
        return 1'b0;
      end
      seg_bytes[1] = len[7:0];
      seg_bytes[2] = b;
      fill_pos = 3'd3;
      if (remaining == 12'd0) begin
        frm = frame_out(1'b1);
        msg_open = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (!msg_open) return 1'b0;
    seg_bytes[fill_pos] = b;
    is_full = (fill_pos == 3'd7);
    fill_pos = fill_pos + 3'd1;
    remaining = remaining - 12'd1;
    is_last = (remaining == 12'd0);
    if (!is_last && !is_full) return 1'b0;
    frm = frame_out(is_last);
    if (is_last) begin
      msg_open = 1'b0;
      return 1'b1;
    end
    seg_bytes[1] = {CF_PCI, seq_no};
    seq_no = seq_no + 4'd1;
    seg_bytes[2:7] = {6{PAD_BYTE}};
    fill_pos = 3'd2;
    return 1'b1;
  endfunction

  task automatic send_item(input logic start, input logic [7:0] b, input logic [11:0] len,
                           input logic typed, input can_frame_t typed_frm);
    can_frame_t predicted;
    bit         produced;
    in_bus.valid      <= 1'b1;
    in_bus.start_req  <= start;
    in_bus.data_byte  <= b;
    in_bus.msg_length <= len;
    do @(posedge clk_i); while (!in_bus.ready);
    if (start || msg_open) items_sent++;
    produced = segment_byte(start, b, len, predicted);
    if (typed) frames_due.push_back(typed_frm);
    else if (produced) frames_due.push_back(predicted);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_message(input logic [11:0] len, input int nbytes);
    send_item(1'b1, 8'($urandom_range(0, 255)), len, 1'b0, '0);
    for (int i = 0; i < nbytes; i++)
      send_item(1'b0, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)), 1'b0, '0);
  endtask

  task automatic send_random_message();
    int         r;
    logic [11:0] len;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 4))
        send_item(1'b0, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)), 1'b0, '0);
    end else if (r < 16) begin
      // Broken message: any length and a random number of bytes, so it may be cut short and abandoned.
      send_message(12'($urandom_range(0, 4095)), $urandom_range(0, 12));
    end else begin
      if (r < 56) len = 12'($urandom_range(0, 6));
      else if (r < 88) len = 12'($urandom_range(7, 40));
      else len = 12'($urandom_range(41, 130));
      send_message(len, (len == 12'd0) ? 0 : int'(len) - 1);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      REG_SENDER_ID: sender_id_q = value;
      REG_TARGET_ID: target_id_q = value;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %0h, got %0h", field, want, got);
  endtask

  task automatic check_frame();
    can_frame_t got;
    can_frame_t want;
    got = {out_bus.frame_id, out_bus.byte_zero, out_bus.byte_one, out_bus.byte_two,
           out_bus.byte_three, out_bus.byte_four, out_bus.byte_five, out_bus.byte_six,
           out_bus.byte_seven, out_bus.final_frame};
    if (frames_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("frame with no expectation: id %0h data %0h", got.frame_id, got.data);
      return;
    end
    want = frames_due.pop_front();
    if (got.frame_id !== want.frame_id) report_mismatch("frame_id", want.frame_id, got.frame_id);
    for (int i = 0; i < 8; i++)
      if (got.data[i] !== want.data[i])
        report_mismatch($sformatf("data byte %0d", i), want.data[i], got.data[i]);
    if (got.final_frame !== want.final_frame)
      report_mismatch("final_frame", want.final_frame, got.final_frame);
  endtask

  // Frame receiver with random stalls and, on request, one long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_frame();
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                 (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] sid;
    logic [7:0] tid;
    int         phase_goal;
    in_bus.valid      = 1'b0;
    in_bus.start_req  = 1'b0;
    in_bus.data_byte  = 8'h00;
    in_bus.msg_length = 12'h000;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_SENDER_ID;
    cfg_bus.data      = 8'h00;
    out_bus.ready     = 1'b0;
    sender_id_q = 8'h00;
    target_id_q = 8'h00;
    seg_bytes   = '0;
    fill_pos    = 3'd0;
    remaining   = 12'd0;
    seq_no      = 4'd0;
    msg_open    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part runs with the register values left by reset.
    idle_odds = 4;
    foreach (dir_rows[i])
      send_item(dir_rows[i].start, dir_rows[i].data, dir_rows[i].len, dir_rows[i].typed,
                {BASE_ID, 8'h00, dir_rows[i].bytes, dir_rows[i].fin});
    in_bus.valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        sid = 8'hFF;
        tid = 8'hFF;
      end else if (ph == 1) begin
        sid = 8'h00;
        tid = 8'h00;
      end else begin
        sid = 8'($urandom_range(0, 255));
        tid = 8'($urandom_range(0, 255));
      end
      write_reg(REG_SENDER_ID, sid);
      write_reg(REG_TARGET_ID, tid);
      calm = (ph == PHASES - 1);
      idle_odds = calm ? 0 : $urandom_range(2, 8);
      if (ph == 2) hold_req <= 1'b1;
      phase_goal = items_sent + ITEMS_PER_PHASE;
      // Long enough for the consecutive-frame number to wrap past 15.
      if (ph == 0) send_message(12'd120, 119);
      while (items_sent < phase_goal) send_random_message();
      in_bus.valid <= 1'b0;
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cantx_pkg.sv
hw/rtl/cantx_intf.sv
hw/rtl/cantx_front.sv
hw/rtl/cantx_fifo.sv
hw/rtl/cantx_back.sv
hw/rtl/can_transport_tx_segmenter.sv
hw/rtl/cantx_checker.sv
test/can_transport_tx_segmenter_tb.sv
